>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/cpng_pkg.sv
package cpng_pkg;

   localparam int unsigned CSR_ADDR_W = 1;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 104;

   localparam logic [CSR_ADDR_W-1:0] CSR_AMPLITUDE  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_STEP = 1'b1;

   localparam logic [15:0] AMPLITUDE_RESET  = 16'd4096;
   localparam logic [31:0] PHASE_STEP_RESET = 32'd6835653;

   // Working width of the rotation datapath (Q1.30 plus headroom)
   localparam int unsigned CW = 34;
   localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;

   typedef struct packed {
      logic                 flip;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } lane_type;

   typedef struct packed {
      logic            valid;
      logic [31:0]     index;
      logic            last;
      lane_type [1:0]  lane;   // lane 0: phase, lane 1: minus half phase
   } cell_type;

   typedef struct packed {
      logic [31:0]        index;
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic               last;
   } result_type;

   // Arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [30:0] atan_turn(input int unsigned idx);
      logic [30:0] v;
      case (idx)
         0:  v = 31'd536870912;
         1:  v = 31'd316933406;
         2:  v = 31'd167458907;
         3:  v = 31'd85004756;
         4:  v = 31'd42667331;
         5:  v = 31'd21354465;
         6:  v = 31'd10679838;
         7:  v = 31'd5340245;
         8:  v = 31'd2670163;
         9:  v = 31'd1335087;
         10: v = 31'd667544;
         11: v = 31'd333772;
         12: v = 31'd166886;
         13: v = 31'd83443;
         14: v = 31'd41722;
         15: v = 31'd20861;
         16: v = 31'd10430;
         17: v = 31'd5215;
         18: v = 31'd2608;
         19: v = 31'd1304;
         20: v = 31'd652;
         21: v = 31'd326;
         22: v = 31'd163;
         23: v = 31'd81;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

endpackage

>>> sv/cpng_cell.sv
module cpng_cell #(
   parameter int unsigned STAGE = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  cpng_pkg::cell_type d_in,
   output cpng_pkg::cell_type q_out
);

   localparam logic signed [cpng_pkg::CW-1:0] ATAN =
      $signed({{(cpng_pkg::CW-31){1'b0}}, cpng_pkg::atan_turn(STAGE)});

   cpng_pkg::cell_type cell_ff;
   cpng_pkg::cell_type cell_in;

   always_comb begin
      cell_in = d_in;
      for (int k = 0; k < 2; k++) begin
         // rotate toward zero residual angle
         if (!d_in.lane[k].z[cpng_pkg::CW-1]) begin
            cell_in.lane[k].x = d_in.lane[k].x - (d_in.lane[k].y >>> STAGE);
            cell_in.lane[k].y = d_in.lane[k].y + (d_in.lane[k].x >>> STAGE);
            cell_in.lane[k].z = d_in.lane[k].z - ATAN;
         end else begin
            cell_in.lane[k].x = d_in.lane[k].x + (d_in.lane[k].y >>> STAGE);
            cell_in.lane[k].y = d_in.lane[k].y - (d_in.lane[k].x >>> STAGE);
            cell_in.lane[k].z = d_in.lane[k].z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (adv) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (adv) begin
         cell_ff.index <= cell_in.index;
         cell_ff.last  <= cell_in.last;
         cell_ff.lane  <= cell_in.lane;
      end
   end

   assign q_out = cell_ff;

endmodule

>>> sv/cpng_post.sv
module cpng_post (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic [15:0]          amplitude,
   input  cpng_pkg::cell_type   d_in,
   output logic                 res_valid,
   output cpng_pkg::result_type res_out
);

   localparam int unsigned CW = cpng_pkg::CW;
   localparam int unsigned PW = CW + 17;

   function automatic logic signed [15:0] quat_round(input logic signed [CW-1:0] v);
      logic signed [CW:0]   sum;
      logic signed [CW-15:0] r;
      sum = $signed({v[CW-1], v}) + $signed((CW+1)'(16384));
      r   = (CW-14)'(sum >>> 15);
      if (r < -32768)
         return 16'sh8000;
      else if (r > 32767)
         return 16'sh7fff;
      else
         return r[15:0];
   endfunction

   function automatic logic signed [16:0] pos_round(input logic signed [PW-1:0] p);
      logic signed [PW:0]    sum;
      logic signed [PW-30:0] r;
      sum = $signed({p[PW-1], p}) + $signed((PW+1)'(64'd536870912));
      r   = (PW-29)'(sum >>> 30);
      if (r < -65536)
         return 17'sh10000;
      else if (r > 65535)
         return 17'sh0ffff;
      else
         return r[16:0];
   endfunction

   // stage A: undo the half-turn fold
   logic                 a_valid_ff;
   logic [31:0]          a_index_ff;
   logic                 a_last_ff;
   logic signed [CW-1:0] a_c0_ff, a_s0_ff, a_c1_ff, a_s1_ff;
   // stage B: scale by amplitude, round the quaternion
   logic                 b_valid_ff;
   logic [31:0]          b_index_ff;
   logic                 b_last_ff;
   logic signed [PW-1:0] b_px_ff, b_py_ff;
   logic signed [15:0]   b_qz_ff, b_qw_ff;
   // stage C: round the position
   logic                 c_valid_ff;
   cpng_pkg::result_type c_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= d_in.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_index_ff <= d_in.index;
         a_last_ff  <= d_in.last;
         a_c0_ff    <= d_in.lane[0].flip ? -d_in.lane[0].x : d_in.lane[0].x;
         a_s0_ff    <= d_in.lane[0].flip ? -d_in.lane[0].y : d_in.lane[0].y;
         a_c1_ff    <= d_in.lane[1].flip ? -d_in.lane[1].x : d_in.lane[1].x;
         a_s1_ff    <= d_in.lane[1].flip ? -d_in.lane[1].y : d_in.lane[1].y;

         b_index_ff <= a_index_ff;
         b_last_ff  <= a_last_ff;
         b_px_ff    <= $signed({1'b0, amplitude}) * a_s0_ff;
         b_py_ff    <= $signed({1'b0, amplitude}) * a_c0_ff;
         b_qz_ff    <= quat_round(a_s1_ff);
         b_qw_ff    <= quat_round(a_c1_ff);

         c_res_ff.index  <= b_index_ff;
         c_res_ff.last   <= b_last_ff;
         c_res_ff.pos_x  <= pos_round(b_px_ff);
         c_res_ff.pos_y  <= pos_round(b_py_ff);
         c_res_ff.quat_z <= b_qz_ff;
         c_res_ff.quat_w <= b_qw_ff;
      end
   end

   assign res_valid = c_valid_ff;
   assign res_out   = c_res_ff;

endmodule

>>> sv/circle_path_point_generator_core.sv
// Channel | Signals                          | Contents
// req     | req_tvalid/tready/tdata/tlast    | tdata[0] start_req, tlast last_point
// rsp     | rsp_tvalid/tready/tdata/tlast    | index, pos x/y, quat z/w; tlast final_flag
// csr     | csr_we/csr_addr/csr_wdata        | 0 amplitude, 1 phase_step
//
// One point per cycle sustained while the skid entry is empty; the phase add and the point index
// counter are the only recurrences. A req transfer loads the phase register and the s0 register,
// then the point passes one rotation cell per stage, three output stages, output register.
// Reset clears the phase, the point index, all valid bits and loads register defaults.
// A one-entry skid behind the output register absorbs a stall; req_tready is low
// only while that skid holds a result.
`include "assert_macros.svh"

module circle_path_point_generator_core #(
   parameter int unsigned PHASE_BITS    = 32,
   parameter int unsigned CORDIC_STAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cpng_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [cpng_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cpng_pkg::REQ_DATA_W-1:0]     req_tdata,  // [0] start_req
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] point_index, [48:32] pos_x, [65:49] pos_y, [81:66] quat_z, [97:82] quat_w
   output logic [cpng_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int unsigned CW = cpng_pkg::CW;

   logic [15:0]           amplitude_ff;
   logic [31:0]           phase_step_ff;
   logic [PHASE_BITS-1:0] phase_ff, phase_in, step_al;
   logic [31:0]           seq_ff, seq_used;
   logic [31:0]           turn_in;
   logic                  adv, accept;

   logic                  s0_valid_ff;
   logic [31:0]           s0_turn_ff, s0_index_ff;
   logic                  s0_last_ff;
   logic [31:0]           half_turn;

   cpng_pkg::cell_type    chain [0:CORDIC_STAGES];
   logic                  post_valid;
   cpng_pkg::result_type  post_res;

   logic                  rsp_valid_ff, skid_valid_ff;
   cpng_pkg::result_type  rsp_res_ff, skid_res_ff;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff  <= cpng_pkg::AMPLITUDE_RESET;
         phase_step_ff <= cpng_pkg::PHASE_STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            cpng_pkg::CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[15:0];
            cpng_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign adv        = !skid_valid_ff;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   generate
      if (PHASE_BITS >= 32) begin : g_wide
         assign step_al = PHASE_BITS'(phase_step_ff) << (PHASE_BITS - 32);
         assign turn_in = phase_in[PHASE_BITS-1 -: 32];
      end else begin : g_narrow
         assign step_al = PHASE_BITS'(phase_step_ff >> (32 - PHASE_BITS));
         assign turn_in = 32'(phase_in) << (32 - PHASE_BITS);
      end
   endgenerate

   assign phase_in = (req_tdata[0] ? '0 : phase_ff) + step_al;
   assign seq_used = req_tdata[0] ? 32'd0 : seq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         seq_ff      <= '0;
         s0_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            seq_ff   <= seq_used + 32'd1;
         end
         if (adv) begin
            s0_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_turn_ff  <= turn_in;
         s0_index_ff <= seq_used;
         s0_last_ff  <= req_tlast;
      end
   end

   // fold each angle into [-1/4, 1/4) turn and seed the rotation
   function automatic cpng_pkg::lane_type seed_lane(input logic [31:0] turn);
      cpng_pkg::lane_type l;
      l.flip = turn[31] ^ turn[30];
      l.x    = cpng_pkg::INV_GAIN_Q30;
      l.y    = '0;
      l.z    = $signed({{(CW-31){turn[30]}}, turn[30:0]});
      return l;
   endfunction

   assign half_turn = 32'd0 - {1'b0, s0_turn_ff[31:1]};

   always_comb begin
      chain[0].valid   = s0_valid_ff;
      chain[0].index   = s0_index_ff;
      chain[0].last    = s0_last_ff;
      chain[0].lane[0] = seed_lane(s0_turn_ff);
      chain[0].lane[1] = seed_lane(half_turn);
   end

   generate
      for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
         cpng_cell #(.STAGE(g)) u_cell (
            .clock (clock),
            .reset (reset),
            .adv   (adv),
            .d_in  (chain[g]),
            .q_out (chain[g+1])
         );
      end
   endgenerate

   cpng_post u_post (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .amplitude (amplitude_ff),
      .d_in      (chain[CORDIC_STAGES]),
      .res_valid (post_valid),
      .res_out   (post_res)
   );

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (rsp_valid_ff && !rsp_tready) begin
         skid_valid_ff <= post_valid;
      end else begin
         rsp_valid_ff <= post_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_res_ff <= skid_res_ff;
         end
      end else if (rsp_valid_ff && !rsp_tready) begin
         skid_res_ff <= post_res;
      end else begin
         rsp_res_ff <= post_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_res_ff.last;
   assign rsp_tdata  = {6'd0,
                        rsp_res_ff.quat_w,
                        rsp_res_ff.quat_z,
                        rsp_res_ff.pos_y,
                        rsp_res_ff.pos_x,
                        rsp_res_ff.index};

   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `ASSERT_NEXT(a_start_index, clock, reset, accept && req_tdata[0], seq_ff == 32'd1)
   `ASSERT_NEXT(a_hold_on_stall, clock, reset, !adv, $stable(s0_valid_ff) && $stable(post_valid))

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

   typedef struct packed {
      logic [31:0]        index;
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
      logic               last;
   } point_type;

   typedef struct {
      bit          wr;
      logic [15:0] amp;
      logic [31:0] step;
      bit          start;
      bit          last;
      bit          chk_idx;
      logic [31:0] idx;
      bit          chk_qw;
      logic [15:0] qw;
   } drive_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [cpng_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [cpng_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [cpng_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // [0] start_req
   logic                            req_tlast = 1'b0; // last_point
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // [31:0] point_index, [48:32] pos_x, [65:49] pos_y, [81:66] quat_z, [97:82] quat_w
   logic [cpng_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;        // final_flag

   circle_path_point_generator_core #(
      .PHASE_BITS(32),
      .CORDIC_STAGES(16)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // arctan(2^-i) in units of 2^-32 turn
   longint arctan_tab [0:15] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861
   };

   // mirror of the generator state and registers
   logic [15:0] amp_reg = cpng_pkg::AMPLITUDE_RESET;
   logic [31:0] step_reg = cpng_pkg::PHASE_STEP_RESET;
   logic [31:0] phase_acc = '0;
   logic [31:0] point_idx = '0;

   point_type point_q [$];
   int        mismatches = 0;
   int        idle_chance = 0;   // out of 64, per item on the sender and per cycle on the receiver
   int        rx_hold = 0;
   int        sent = 0;

   drive_row_type dir_rows [0:20] = '{
      // reset values, first point after reset has index zero
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b1, 32'd1, 1'b0, 16'd0},
      // zero step: phase stays at zero, cosine of zero saturates
      '{1'b1, 16'd4096, 32'd0, 1'b1, 1'b0, 1'b1, 32'd0, 1'b1, 16'h7FFF},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1, 32'd1, 1'b1, 16'h7FFF},
      '{1'b0, 16'd0, 32'd0, 1'b1, 1'b1, 1'b1, 32'd0, 1'b1, 16'h7FFF},
      // quarter turns at the largest radius, wrap back to zero
      '{1'b1, 16'hFFFF, 32'h4000_0000, 1'b1, 1'b0, 1'b1, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 16'd0},
      // zero radius, half turns
      '{1'b1, 16'd0, 32'h8000_0000, 1'b1, 1'b0, 1'b1, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 16'd0},
      // largest step: phase walks backward one unit at a time
      '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 16'd0},
      // eighth turns, from one eighth to five eighths of a turn
      '{1'b1, 16'hFFFF, 32'h2000_0000, 1'b1, 1'b0, 1'b1, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 16'd0},
      '{1'b1, 16'd12345, 32'h1555_5555, 1'b1, 1'b0, 1'b1, 32'd0, 1'b0, 16'd0},
      '{1'b0, 16'd0, 32'd0, 1'b0, 1'b1, 1'b0, 32'd0, 1'b0, 16'd0}
   };

   // rotation-mode CORDIC, angle in 2^-32 turn, results in Q1.30
   function automatic void cordic_cs(input logic [31:0] ang, output longint c,
                                     output longint s);
      logic        flip;
      logic [31:0] r;
      longint      x, y, z, dx, dy;
      flip = ang[31] ^ ang[30];
      r = flip ? (ang ^ 32'h8000_0000) : ang;
      z = $signed(r);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_tab[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_tab[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endfunction

   function automatic longint round_sat(input longint v, input int sh, input longint lo,
                                        input longint hi);
      longint r;
      r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (r < lo) return lo;
      if (r > hi) return hi;
      return r;
   endfunction

   function automatic point_type predict_point(input bit start, input bit last);
      longint      c, s, amp;
      logic [31:0] half;
      point_type   p;
      if (start) begin
         phase_acc = '0;
         point_idx = '0;
      end
      phase_acc = phase_acc + step_reg;
      amp = longint'(amp_reg);
      cordic_cs(phase_acc, c, s);
      p.x = 17'(round_sat(amp * s, 30, -65536, 65535));
      p.y = 17'(round_sat(amp * c, 30, -65536, 65535));
      half = 32'd0 - (phase_acc >> 1);
      cordic_cs(half, c, s);
      p.z = 16'(round_sat(s, 15, -32768, 32767));
      p.w = 16'(round_sat(c, 15, -32768, 32767));
      p.index = point_idx;
      p.last = last;
      point_idx = point_idx + 32'd1;
      return p;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   // hold off new requests until every outstanding point is back
   task automatic drain_points;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (point_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_circle(input logic [15:0] amp, input logic [31:0] step);
      drain_points();
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = cpng_pkg::CSR_AMPLITUDE;
      csr_wdata = ($urandom & 32'hFFFF_0000) | {16'd0, amp};
      @(negedge clock);
      csr_addr = cpng_pkg::CSR_PHASE_STEP;
      csr_wdata = step;
      @(negedge clock);
      csr_we = 1'b0;
      amp_reg = amp;
      step_reg = step;
   endtask

   task automatic send_point(input bit start, input bit last, input bit chk_idx,
                             input logic [31:0] idx, input bit chk_qw,
                             input logic [15:0] qw);
      point_type p;
      if ($urandom_range(0, 63) < idle_chance) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 16)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = '0;
      req_tdata[0] = start;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      p = predict_point(start, last);
      if (chk_idx) p.index = idx;
      if (chk_qw) p.w = qw;
      point_q.insert(point_q.size(), p);
      sent++;
   endtask

   always @(negedge clock) begin
      if (rx_hold != 0) begin
         rx_hold--;
         rsp_tready = 1'b0;
      end else if ($urandom_range(0, 63) < idle_chance) begin
         rx_hold = $urandom_range(0, 16);
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      point_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.index = rsp_tdata[31:0];
         got.x = rsp_tdata[48:32];
         got.y = rsp_tdata[65:49];
         got.z = rsp_tdata[81:66];
         got.w = rsp_tdata[97:82];
         got.last = rsp_tlast;
         if (point_q.size() == 0) begin
            report_mismatch("unexpected point_index", got.index, -1);
         end else begin
            want = point_q.pop_front();
            if (got.index !== want.index) report_mismatch("point_index", got.index, want.index);
            if (got.x !== want.x) report_mismatch("pos_x", got.x, want.x);
            if (got.y !== want.y) report_mismatch("pos_y", got.y, want.y);
            if (got.z !== want.z) report_mismatch("quat_z", got.z, want.z);
            if (got.w !== want.w) report_mismatch("quat_w", got.w, want.w);
            if (got.last !== want.last) report_mismatch("final_flag", got.last, want.last);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] amp;
      logic [31:0] step;
      bit          start, last, prev_last;
      int          n;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_chance = 10;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].wr) set_circle(dir_rows[i].amp, dir_rows[i].step);
         send_point(dir_rows[i].start, dir_rows[i].last, dir_rows[i].chk_idx,
                    dir_rows[i].idx, dir_rows[i].chk_qw, dir_rows[i].qw);
      end

      prev_last = 1'b0;
      while (sent < 1471) begin
         case ($urandom_range(0, 4))
            0: amp = 16'd0;
            1: amp = 16'hFFFF;
            2: amp = 16'd4096;
            default: amp = 16'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 6))
            0: step = 32'd0;
            1: step = 32'hFFFF_FFFF;
            2: step = 32'h8000_0000;
            3: step = $urandom_range(0, 1 << 24);
            default: step = $urandom;
         endcase
         set_circle(amp, step);
         if (sent < 1320) begin
            n = $urandom_range(60, 200);
            case ($urandom_range(0, 3))
               0: idle_chance = 0;
               1: idle_chance = 6;
               2: idle_chance = 20;
               default: idle_chance = 40;
            endcase
         end else begin
            // closing stretch at full rate
            n = 1471 - sent;
            idle_chance = 0;
         end
         repeat (n) begin
            // a new path usually follows the end of the previous one
            start = prev_last ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 31) == 0);
            last = ($urandom_range(0, 7) == 0);
            send_point(start, last, 1'b0, '0, 1'b0, '0);
            prev_last = last;
         end
      end

      drain_points();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && point_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
